// ===== hdl/lkv_pkg.sv =====
// ----------------------------------------------------------------------------
// lkv_pkg
// Shared types and constants for the LRU key-value cache.
// ----------------------------------------------------------------------------
package lkv_pkg;

    localparam int ENTRIES_DEF = 16;
    localparam int CAP_W       = 5;
    localparam int KEY_W       = 32;
    localparam int VAL_W       = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    // which cell an update lands on
    typedef enum logic [1:0] {
        SEL_MATCH  = 2'd0,
        SEL_FREE   = 2'd1,
        SEL_VICTIM = 2'd2
    } t_sel;

    // update command broadcast to every cell
    typedef struct packed {
        logic upd;
        logic wr_key;
        logic wr_val;
        t_sel sel;
    } t_ctl;

    // words passed from cell to cell
    typedef struct packed {
        logic             hit;
        logic             free_seen;
        logic [VAL_W-1:0] value;
    } t_chain;

endpackage

// ===== hdl/lkv_cell.sv =====
// ----------------------------------------------------------------------------
// lkv_cell
// One cache slot: valid, key, value and recency rank, with its link in the
// hit / free / readout chain.
// ----------------------------------------------------------------------------
module lkv_cell #(
    parameter  int ENTRIES = lkv_pkg::ENTRIES_DEF,
    localparam int RW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
    localparam int OCW     = $clog2(ENTRIES + 1)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_look,
    input  logic [lkv_pkg::KEY_W-1:0] i_key,
    input  logic [lkv_pkg::VAL_W-1:0] i_val,
    input  logic [OCW-1:0]            i_victim_rank,
    input  lkv_pkg::t_ctl             i_ctl,
    input  logic [OCW-1:0]            i_limit,
    input  lkv_pkg::t_chain           i_chain,
    input  logic [RW-1:0]             i_rank_chain,
    output lkv_pkg::t_chain           o_chain,
    output logic [RW-1:0]             o_rank_chain
);

    logic                      r_valid;
    logic [lkv_pkg::KEY_W-1:0] r_key;
    logic [lkv_pkg::VAL_W-1:0] r_value;
    logic [RW-1:0]             r_rank;
    logic                      r_match;
    logic                      r_victim;

    logic       match;
    logic       tgt;
    logic [OCW-1:0] rank_ext;

    assign match    = r_valid && (r_key == i_key);
    assign rank_ext = OCW'(r_rank);

    assign o_chain.hit       = i_chain.hit | match;
    assign o_chain.free_seen = i_chain.free_seen | !r_valid;
    assign o_chain.value     = i_chain.value | (match ? r_value : '0);
    assign o_rank_chain      = i_rank_chain | (match ? r_rank : '0);

    always_comb begin
        case (i_ctl.sel)
            lkv_pkg::SEL_MATCH:  tgt = r_match;
            lkv_pkg::SEL_FREE:   tgt = !r_valid && !i_chain.free_seen;
            lkv_pkg::SEL_VICTIM: tgt = r_victim;
            default:             tgt = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.upd && tgt) begin
            r_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_look) begin
            r_match  <= match;
            r_victim <= r_valid && (rank_ext == i_victim_rank);
        end
        if (i_ctl.upd) begin
            if (tgt) begin
                if (i_ctl.wr_key) r_key <= i_key;
                if (i_ctl.wr_val) r_value <= i_val;
                r_rank <= '0;
            end else if (r_valid && (rank_ext < i_limit)) begin
                r_rank <= r_rank + RW'(1);
            end
        end
    end

endmodule

// ===== hdl/lru_key_value_cache_top.sv =====
// ----------------------------------------------------------------------------
// lru_key_value_cache_top
// Fully associative key-value cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Each command is captured in S_IDLE, then passes S_LOOK, where every slot
// cell compares the key and the hit value and rank ripple down the cell
// chain, and S_UPDT, where the chosen cell is written and the others age.
// busy is high in S_LOOK and S_UPDT; the result word appears on o_valid for
// one cycle right after, and start may be raised again in that same cycle.
// The receiver cannot stall, so results must be taken when o_valid is high.
// A get returns the value on a hit and -1 on a miss; a put returns 0.
// capacity 0 acts as 1, capacity above ENTRIES acts as ENTRIES.
module lru_key_value_cache_top #(
    parameter int ENTRIES = lkv_pkg::ENTRIES_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic                      i_op,
    input  logic [lkv_pkg::KEY_W-1:0] i_lookup_key,
    input  logic [lkv_pkg::VAL_W-1:0] i_write_value,
    input  logic                      i_cfg_we,
    input  logic [lkv_pkg::CAP_W-1:0] i_cfg_wdata,
    output logic                      o_valid,
    output logic                      o_hit,
    output logic [lkv_pkg::VAL_W-1:0] o_read_value
);

    localparam int RW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OCW = $clog2(ENTRIES + 1);
    localparam int CW  = (OCW > lkv_pkg::CAP_W) ? OCW : lkv_pkg::CAP_W;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_LOOK = 3'b010,
        S_UPDT = 3'b100
    } t_state;

    t_state                      r_state;
    logic                        r_op;
    logic [lkv_pkg::KEY_W-1:0]   r_key;
    logic [lkv_pkg::VAL_W-1:0]   r_wval;
    logic [lkv_pkg::CAP_W-1:0]   r_cap;
    logic [OCW-1:0]              r_occ;
    logic                        r_hit;
    logic [lkv_pkg::VAL_W-1:0]   r_hval;
    logic [RW-1:0]               r_hrank;
    logic                        r_ovalid;
    logic                        r_ohit;
    logic [lkv_pkg::VAL_W-1:0]   r_oval;

    lkv_pkg::t_chain             chain [ENTRIES+1];
    logic [RW-1:0]               rank_chain [ENTRIES+1];
    lkv_pkg::t_ctl               ctl;
    logic [OCW-1:0]              limit;
    logic [OCW-1:0]              victim_rank;
    logic [CW-1:0]               cap_ext;
    logic [CW-1:0]               occ_ext;
    logic                        room;
    logic                        accept;

    assign accept = start && !busy;
    assign busy   = (r_state != S_IDLE);

    assign chain[0]      = '0;
    assign rank_chain[0] = '0;

    assign victim_rank = r_occ - OCW'(1);
    assign occ_ext     = CW'(r_occ);
    assign cap_ext     = (r_cap == '0) ? CW'(1) : CW'(r_cap);
    assign room        = (occ_ext < cap_ext) && (occ_ext < CW'(ENTRIES));

    always_comb begin
        ctl.upd    = (r_state == S_UPDT) && (r_hit || (r_op == lkv_pkg::OP_PUT));
        ctl.wr_key = !r_hit;
        ctl.wr_val = (r_op == lkv_pkg::OP_PUT);
        if (r_hit) begin
            ctl.sel = lkv_pkg::SEL_MATCH;
            limit   = OCW'(r_hrank);
        end else if (room) begin
            ctl.sel = lkv_pkg::SEL_FREE;
            limit   = OCW'(ENTRIES);
        end else begin
            ctl.sel = lkv_pkg::SEL_VICTIM;
            limit   = victim_rank;
        end
    end

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        lkv_cell #(
            .ENTRIES (ENTRIES)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_look        (r_state == S_LOOK),
            .i_key         (r_key),
            .i_val         (r_wval),
            .i_victim_rank (victim_rank),
            .i_ctl         (ctl),
            .i_limit       (limit),
            .i_chain       (chain[g]),
            .i_rank_chain  (rank_chain[g]),
            .o_chain       (chain[g+1]),
            .o_rank_chain  (rank_chain[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cap    <= lkv_pkg::CAP_RESET;
            r_occ    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) r_cap <= i_cfg_wdata;
            r_ovalid <= (r_state == S_UPDT);
            unique case (r_state)
                S_IDLE: begin
                    if (accept) r_state <= S_LOOK;
                end
                S_LOOK: begin
                    r_state <= S_UPDT;
                end
                S_UPDT: begin
                    r_state <= S_IDLE;
                    if ((r_op == lkv_pkg::OP_PUT) && !r_hit && room) begin
                        r_occ <= r_occ + OCW'(1);
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op   <= i_op;
            r_key  <= i_lookup_key;
            r_wval <= i_write_value;
        end
        if (r_state == S_LOOK) begin
            r_hit   <= chain[ENTRIES].hit;
            r_hval  <= chain[ENTRIES].value;
            r_hrank <= rank_chain[ENTRIES];
        end
        if (r_state == S_UPDT) begin
            r_ohit <= r_hit;
            if (r_op == lkv_pkg::OP_PUT) begin
                r_oval <= '0;
            end else if (r_hit) begin
                r_oval <= r_hval;
            end else begin
                r_oval <= '1;
            end
        end
    end

    assign o_valid      = r_ovalid;
    assign o_hit        = r_ohit;
    assign o_read_value = r_oval;

`ifndef SYNTH
    a_strobe_after_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state == S_UPDT))
        else $error("result strobe without update cycle");

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        occ_ext <= CW'(ENTRIES))
        else $error("occupancy above entry count");

    a_occ_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_occ != $past(r_occ)) |-> (r_occ == $past(r_occ) + OCW'(1)))
        else $error("occupancy moved by other than one");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (busy && !o_valid) ##1 (busy && !o_valid) ##1 (!busy && o_valid))
        else $error("command did not take three cycles");
`endif

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Testbench for the LRU key-value cache: a shadow copy of the cache predicts
// each reply word, which is checked field by field as it comes out.
// ----------------------------------------------------------------------------
module tb;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int PHASE_ITEMS   = 84;
    localparam int NUM_PHASES    = 9;
    localparam int POOL_SIZE     = 32;
    localparam int POOL_IW       = $clog2(POOL_SIZE);
    localparam int QUIET_PHASE   = 4;

    typedef struct {
        logic                      hit;
        logic [lkv_pkg::VAL_W-1:0] value;
    } t_reply;

    // shadow of the cache contents, recency ranks and capacity register
    class lru_mirror;
        bit [lkv_pkg::CAP_W-1:0] capacity;
        bit                      used [lkv_pkg::ENTRIES_DEF];
        bit [lkv_pkg::KEY_W-1:0] keys [lkv_pkg::ENTRIES_DEF];
        bit [lkv_pkg::VAL_W-1:0] vals [lkv_pkg::ENTRIES_DEF];
        int unsigned             rank [lkv_pkg::ENTRIES_DEF];
        int unsigned             fill;
        t_reply                  due_replies [$];
        int                      mismatches;

        function new();
            capacity   = lkv_pkg::CAP_RESET;
            fill       = 0;
            mismatches = 0;
            foreach (used[i]) begin
                used[i] = 1'b0;
                rank[i] = 0;
            end
        endfunction

        function void set_capacity(bit [lkv_pkg::CAP_W-1:0] cap);
            capacity = cap;
        endfunction

        function int outstanding();
            return due_replies.size();
        endfunction

        function int unsigned usable_slots();
            int unsigned c;
            c = 32'(capacity);
            if (c == 0) c = 1;
            if (c > lkv_pkg::ENTRIES_DEF) c = lkv_pkg::ENTRIES_DEF;
            return c;
        endfunction

        // slot s becomes most recent; entries ranked below limit age by one
        function void promote(int s, int unsigned limit);
            for (int i = 0; i < lkv_pkg::ENTRIES_DEF; i++) begin
                if (i != s && used[i] && rank[i] < limit) rank[i] += 1;
            end
            rank[s] = 0;
        endfunction

        function void take_command(bit op, bit [lkv_pkg::KEY_W-1:0] key,
                                   bit [lkv_pkg::VAL_W-1:0] val);
            int     s;
            int     f;
            int     v;
            t_reply r;
            s = -1;
            for (int i = 0; i < lkv_pkg::ENTRIES_DEF; i++) begin
                if (s < 0 && used[i] && keys[i] == key) s = i;
            end
            r.hit   = (s >= 0);
            r.value = '0;
            if (op == lkv_pkg::OP_GET) begin
                if (s >= 0) begin
                    promote(s, rank[s]);
                    r.value = vals[s];
                end else begin
                    r.value = '1;
                end
            end else if (s >= 0) begin
                vals[s] = val;
                promote(s, rank[s]);
            end else begin
                f = -1;
                if (fill < usable_slots()) begin
                    for (int i = 0; i < lkv_pkg::ENTRIES_DEF; i++) begin
                        if (f < 0 && !used[i]) f = i;
                    end
                end
                if (f >= 0) begin
                    used[f] = 1'b1;
                    keys[f] = key;
                    vals[f] = val;
                    rank[f] = 0;
                    promote(f, lkv_pkg::ENTRIES_DEF);
                    fill += 1;
                end else begin
                    // evict only the single least recent entry
                    v = -1;
                    for (int i = 0; i < lkv_pkg::ENTRIES_DEF; i++) begin
                        if (used[i] && (v < 0 || rank[i] > rank[v])) v = i;
                    end
                    if (v >= 0) begin
                        keys[v] = key;
                        vals[v] = val;
                        promote(v, rank[v]);
                    end
                end
            end
            due_replies.push_back(r);
        endfunction

        task report_mismatch(string msg);
            $display("mismatch at %0t: %s", $time, msg);
            mismatches++;
        endtask

        task check_reply(logic hit, logic [lkv_pkg::VAL_W-1:0] value);
            t_reply w;
            if (due_replies.size() == 0) begin
                report_mismatch($sformatf("reply word with none due (hit %b value %h)",
                                          hit, value));
                return;
            end
            w = due_replies.pop_front();
            if (hit !== w.hit)
                report_mismatch($sformatf("hit %b, want %b", hit, w.hit));
            if (value !== w.value)
                report_mismatch($sformatf("read_value %h, want %h", value, w.value));
        endtask
    endclass

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      busy;
    logic                      i_op = lkv_pkg::OP_GET;
    logic [lkv_pkg::KEY_W-1:0] i_lookup_key = '0;
    logic [lkv_pkg::VAL_W-1:0] i_write_value = '0;
    logic                      i_cfg_we = 1'b0;
    logic [lkv_pkg::CAP_W-1:0] i_cfg_wdata = '0;
    logic                      o_valid;
    logic                      o_hit;
    logic [lkv_pkg::VAL_W-1:0] o_read_value;

    lru_mirror   mirror = new();
    bit          quiet_stretch = 1'b0;
    int unsigned cycles = 0;

    lru_key_value_cache_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_op         (i_op),
        .i_lookup_key (i_lookup_key),
        .i_write_value(i_write_value),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_valid      (o_valid),
        .o_hit        (o_hit),
        .o_read_value (o_read_value)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) mirror.check_reply(o_hit, o_read_value);
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    // sender gap: outside the quiet stretch, start is dropped about 38 times in 100
    task idle_gap();
        int unsigned span;
        if (!quiet_stretch && $urandom_range(0, 99) < 38) begin
            span  = ($urandom_range(0, 4) == 0) ? 12 : 3;
            start = 1'b0;
            repeat ($urandom_range(1, span)) @(negedge i_clk);
        end
    endtask

    // called at a falling edge; returns at a falling edge after acceptance and any sender gap
    task run_command(bit op, bit [lkv_pkg::KEY_W-1:0] key, bit [lkv_pkg::VAL_W-1:0] val);
        i_op          = op;
        i_lookup_key  = key;
        i_write_value = val;
        start         = 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
        mirror.take_command(op, key, val);
        @(negedge i_clk);
        idle_gap();
    endtask

    task wait_idle();
        start = 1'b0;
        while (mirror.outstanding() != 0) @(posedge i_clk);
        @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    task program_capacity(bit [lkv_pkg::CAP_W-1:0] cap);
        wait_idle();
        i_cfg_we    = 1'b1;
        i_cfg_wdata = cap;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        mirror.set_capacity(cap);
    endtask

    initial begin
        bit [lkv_pkg::KEY_W-1:0] key_pool [POOL_SIZE];
        bit [lkv_pkg::CAP_W-1:0] phase_caps [NUM_PHASES];
        int unsigned             span;
        int unsigned             base;
        bit [lkv_pkg::KEY_W-1:0] key;
        bit [lkv_pkg::VAL_W-1:0] val;
        bit                      op;

        phase_caps = '{5'd3, 5'd1, 5'd0, 5'd31, 5'd8, 5'd17, 5'd2, 5'd16, 5'd5};
        foreach (key_pool[i]) key_pool[i] = $urandom;
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7FFF_FFFF;
        key_pool[2] = 32'h0000_0000;
        key_pool[3] = 32'hFFFF_FFFF;

        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed: empty cache, extreme keys and values, update in place
        run_command(lkv_pkg::OP_GET, 32'h0000_0000, 32'h0000_0000);
        run_command(lkv_pkg::OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
        run_command(lkv_pkg::OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
        run_command(lkv_pkg::OP_PUT, 32'h0000_0000, 32'h0000_0000);
        run_command(lkv_pkg::OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        run_command(lkv_pkg::OP_GET, 32'hFFFF_FFFF, 32'h0000_0000); // hit that reads all ones
        run_command(lkv_pkg::OP_GET, 32'h8000_0000, 32'hFFFF_FFFF);
        run_command(lkv_pkg::OP_PUT, 32'h7FFF_FFFF, 32'h1234_5678);
        run_command(lkv_pkg::OP_GET, 32'h7FFF_FFFF, 32'h0000_0000);
        run_command(lkv_pkg::OP_GET, 32'h0000_0001, 32'h0000_0000);

        // capacity dropped below occupancy: each new key evicts one entry
        program_capacity(5'd2);
        run_command(lkv_pkg::OP_PUT, 32'h0000_0100, 32'hA5A5_A5A5);
        run_command(lkv_pkg::OP_GET, 32'h0000_0000, 32'h0000_0000);
        run_command(lkv_pkg::OP_PUT, 32'h0000_0200, 32'h5A5A_5A5A);
        run_command(lkv_pkg::OP_GET, 32'h0000_0100, 32'h0000_0000);

        // zero capacity behaves as one
        program_capacity(5'd0);
        run_command(lkv_pkg::OP_PUT, 32'h0000_0300, 32'h0000_0300);
        run_command(lkv_pkg::OP_GET, 32'h0000_0300, 32'h0000_0000);

        // above the slot count: clamps, free slots refill
        program_capacity(5'd31);
        run_command(lkv_pkg::OP_PUT, 32'h0000_1000, 32'h0000_0001);
        run_command(lkv_pkg::OP_PUT, 32'h0000_2000, 32'h0000_0002);
        run_command(lkv_pkg::OP_PUT, 32'h0000_3000, 32'h0000_0003);
        run_command(lkv_pkg::OP_GET, 32'h0000_2000, 32'h0000_0000);
        run_command(lkv_pkg::OP_PUT, 32'h0000_1000, 32'hDEAD_BEEF);
        run_command(lkv_pkg::OP_GET, 32'h0000_1000, 32'h0000_0000);

        for (int p = 0; p < NUM_PHASES; p++) begin
            program_capacity(phase_caps[p]);
            quiet_stretch = (p == QUIET_PHASE);
            span = (phase_caps[p] == 0) ? 1 : 32'(phase_caps[p]);
            if (span > lkv_pkg::ENTRIES_DEF) span = lkv_pkg::ENTRIES_DEF;
            span += 4;
            base = $urandom_range(0, POOL_SIZE - 1);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                op = 1'($urandom_range(0, 1));
                if ($urandom_range(0, 3) == 0)
                    key = $urandom;
                else
                    key = key_pool[POOL_IW'((base + $urandom_range(0, span - 1)) % POOL_SIZE)];
                case ($urandom_range(0, 9))
                    0:       val = 32'h8000_0000;
                    1:       val = 32'hFFFF_FFFF;
                    default: val = $urandom;
                endcase
                run_command(op, key, val);
            end
        end
        quiet_stretch = 1'b0;

        wait_idle();
        repeat (8) @(posedge i_clk);
        if (mirror.mismatches == 0 && mirror.outstanding() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== lru_key_value_cache_top.f =====
hdl/lkv_pkg.sv
hdl/lkv_cell.sv
hdl/lru_key_value_cache_top.sv
tb/tb.sv
